@@ hdl/spslb_pkg.sv @@
// Shared types, field widths and helpers for the sparse pattern list builder.
package spslb_pkg;

    // Default sizes of the entry pool and of the column table.
    localparam int unsigned POOL_ENTRIES_DEF = 4096;
    localparam int unsigned MAX_BUSES_DEF    = 1024;

    // Fixed field widths of the stream payloads.
    localparam int BUS_W       = 10;
    localparam int ADDR_W      = 12;
    localparam int CFG_W       = 11;
    localparam int COUNT_W     = 11;
    localparam int FREE_W      = 13;
    localparam int EROW_W      = 11;
    localparam int ENEXT_W     = 13;
    localparam int FIRST_W     = 12;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 80;

    // Bus count after reset.
    localparam logic [CFG_W-1:0] BUS_COUNT_RST = 11'd1024;

    typedef enum logic [1:0] {
        MODE_INIT    = 2'd0,
        MODE_ADD     = 2'd1,
        MODE_RD_POOL = 2'd2,
        MODE_RD_COL  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POOL_FULL = 2'd1,
        ST_RANGE     = 2'd2
    } status_t;

    // One decoded request as it waits in the front queue.
    typedef struct packed {
        mode_t              mode;
        logic [BUS_W-1:0]   from_bus;
        logic [BUS_W-1:0]   to_bus;
        logic [ADDR_W-1:0]  address;
        logic               last_branch;
    } item_t;

    // Status from the back end to the front end.
    typedef struct packed {
        logic busy_clear;
        logic pop;
    } back_stat_t;

    // Number of active columns for a given bus count.
    function automatic int unsigned clamp_buses(input logic [CFG_W-1:0] bc,
                                                input int unsigned max_b,
                                                input int unsigned pool);
        int unsigned nb;
        nb = int'(bc);
        if (nb > max_b) nb = max_b;
        if (nb > pool) nb = pool;
        return nb;
    endfunction

endpackage

@@ hdl/spslb_front.sv @@
// Front end: accepts requests, decodes them and holds them in a two-entry queue.
module spslb_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [spslb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                               s_axis_tlast,
    input  spslb_pkg::back_stat_t              stat,
    output logic                               q_valid,
    output spslb_pkg::item_t                   q_item
);

    spslb_pkg::item_t slot_reg [2];
    logic             rd_ptr_reg;
    logic             wr_ptr_reg;
    logic [1:0]       cnt_reg;
    spslb_pkg::item_t dec_item;
    logic             push;
    logic             pop;

    // Decode the packed request fields.
    always_comb
    begin
        dec_item.mode        = spslb_pkg::mode_t'(s_axis_tdata[1:0]);
        dec_item.from_bus    = s_axis_tdata[11:2];
        dec_item.to_bus      = s_axis_tdata[21:12];
        dec_item.address     = s_axis_tdata[33:22];
        dec_item.last_branch = s_axis_tlast;
    end

    // No request is taken while the pool is cleared after reset.
    assign s_axis_tready = (cnt_reg != 2'd2) && !stat.busy_clear;
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = stat.pop && q_valid;
    assign q_valid       = (cnt_reg != 2'd0);
    assign q_item        = slot_reg[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= dec_item;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop) rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop) cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push) cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

@@ hdl/spslb_back.sv @@
// Back end: column table, entry pool, list insertion sequencer and result register.
module spslb_back
#(
    parameter int unsigned POOL_ENTRIES = spslb_pkg::POOL_ENTRIES_DEF,
    parameter int unsigned MAX_BUSES    = spslb_pkg::MAX_BUSES_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [spslb_pkg::CFG_W-1:0]        cfg_wr_data,
    input  logic                               q_valid,
    input  spslb_pkg::item_t                   q_item,
    output spslb_pkg::back_stat_t              stat,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [spslb_pkg::OUT_TDATA_W-1:0]  out_data
);

    localparam int PW    = $clog2(POOL_ENTRIES);
    localparam int BW    = $clog2(MAX_BUSES);
    localparam int AW    = $clog2(MAX_BUSES + 1);
    localparam int FPW   = $clog2(POOL_ENTRIES + 1);
    localparam int RW    = BW + 1;
    localparam int NW    = PW + 1;
    localparam int unsigned SWEEP = (POOL_ENTRIES > MAX_BUSES) ? POOL_ENTRIES : MAX_BUSES;
    localparam int SCW   = $clog2(SWEEP + 1);
    localparam int CMPW  = ((AW > spslb_pkg::BUS_W) ? AW : spslb_pkg::BUS_W) + 1;
    localparam int unsigned RST_NB =
        spslb_pkg::clamp_buses(spslb_pkg::BUS_COUNT_RST, MAX_BUSES, POOL_ENTRIES);

    typedef struct packed {
        logic signed [RW-1:0] row;
        logic signed [NW-1:0] nxt;
    } pword_t;

    typedef struct packed {
        logic [PW-1:0] head;
        logic [AW-1:0] cnt;
    } cword_t;

    typedef enum logic [4:0] {
        S_SWEEP, S_IDLE,
        S_I_COL, S_I_HEAD, S_I_CMPH, S_I_WALK, S_I_CMP, S_I_LINK, S_I_LINK2, S_I_END,
        S_P_RD, S_P_GET, S_H_RD, S_H_GET,
        S_CNT_A, S_CNT_B, S_CNT_C, S_OUT
    } state_t;

    // Memories.
    pword_t pool_mem [POOL_ENTRIES];
    cword_t col_mem  [MAX_BUSES];
    pword_t pool_rdata_reg;
    cword_t col_rdata_reg;

    logic          pool_we;
    logic [PW-1:0] pool_waddr;
    pword_t        pool_wdata;
    logic [PW-1:0] pool_raddr;
    logic          col_we;
    logic [BW-1:0] col_waddr;
    cword_t        col_wdata;
    logic [BW-1:0] col_raddr;

    // Control and working registers.
    state_t                          state_reg;
    logic [spslb_pkg::CFG_W-1:0]     bus_count_reg;
    logic [AW-1:0]                   active_reg;
    logic [FPW-1:0]                  fp_reg;
    logic                            full_reg;
    logic [SCW-1:0]                  sweep_reg;
    logic                            has_item_reg;
    logic                            second_reg;
    spslb_pkg::item_t                it_reg;
    logic [BW-1:0]                   ins_col_reg;
    logic signed [RW-1:0]            ins_row_reg;
    logic [PW-1:0]                   head_reg;
    logic [AW-1:0]                   cnt_reg;
    logic [PW-1:0]                   prev_reg;
    logic signed [RW-1:0]            prev_row_reg;
    logic signed [NW-1:0]            cur_reg;
    spslb_pkg::status_t              status_reg;
    logic [spslb_pkg::COUNT_W-1:0]   cf_reg;
    logic [spslb_pkg::COUNT_W-1:0]   ct_reg;
    logic [spslb_pkg::EROW_W-1:0]    erow_reg;
    logic [spslb_pkg::ENEXT_W-1:0]   enext_reg;
    logic [spslb_pkg::FIRST_W-1:0]   first_reg;
    logic                            out_valid_reg;
    logic [spslb_pkg::OUT_TDATA_W-1:0] out_data_reg;

    logic fb_ok;
    logic tb_ok;
    logic q_fb_ok;
    logic q_tb_ok;
    logic fp_high;
    int unsigned new_nb;

    assign fb_ok   = CMPW'(it_reg.from_bus) < CMPW'(active_reg);
    assign tb_ok   = CMPW'(it_reg.to_bus) < CMPW'(active_reg);
    assign q_fb_ok = CMPW'(q_item.from_bus) < CMPW'(active_reg);
    assign q_tb_ok = CMPW'(q_item.to_bus) < CMPW'(active_reg);
    assign fp_high = 32'(fp_reg) >= 32'(POOL_ENTRIES - 1);
    assign new_nb  = spslb_pkg::clamp_buses(bus_count_reg, MAX_BUSES, POOL_ENTRIES);

    assign stat.busy_clear = (state_reg == S_SWEEP) && !has_item_reg;
    assign stat.pop        = (state_reg == S_IDLE) && q_valid;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

    // Memory ports.
    always_ff @(posedge clk)
    begin
        if (pool_we) pool_mem[pool_waddr] <= pool_wdata;
        pool_rdata_reg <= pool_mem[pool_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (col_we) col_mem[col_waddr] <= col_wdata;
        col_rdata_reg <= col_mem[col_raddr];
    end

    // Read addresses follow the sequencer state.
    always_comb
    begin
        case (state_reg)
            S_H_RD, S_CNT_A: col_raddr = BW'(it_reg.from_bus);
            S_CNT_B:         col_raddr = BW'(it_reg.to_bus);
            default:         col_raddr = ins_col_reg;
        endcase
        case (state_reg)
            S_I_HEAD: pool_raddr = col_rdata_reg.head;
            S_P_RD:   pool_raddr = PW'(it_reg.address);
            default:  pool_raddr = cur_reg[PW-1:0];
        endcase
    end

    // Write ports: the clearing sweep and the list updates.
    always_comb
    begin
        pool_we    = 1'b0;
        pool_waddr = fp_reg[PW-1:0];
        pool_wdata = '{row: ins_row_reg, nxt: cur_reg};
        col_we     = 1'b0;
        col_waddr  = ins_col_reg;
        col_wdata  = '{head: head_reg, cnt: cnt_reg + AW'(1)};
        case (state_reg)
            S_SWEEP:
            begin
                pool_we    = 32'(sweep_reg) < 32'(POOL_ENTRIES);
                pool_waddr = sweep_reg[PW-1:0];
                if (32'(sweep_reg) < 32'(active_reg))
                begin
                    pool_wdata = '{row: RW'(sweep_reg), nxt: '1};
                end
                else if (32'(sweep_reg) == 32'(POOL_ENTRIES - 1))
                begin
                    pool_wdata = '{row: '1, nxt: '1};
                end
                else
                begin
                    pool_wdata = '{row: '1, nxt: NW'(sweep_reg + SCW'(1))};
                end
                col_we    = 32'(sweep_reg) < 32'(MAX_BUSES);
                col_waddr = sweep_reg[BW-1:0];
                if (32'(sweep_reg) < 32'(active_reg))
                begin
                    col_wdata = '{head: PW'(sweep_reg), cnt: AW'(1)};
                end
                else
                begin
                    col_wdata = '{head: '0, cnt: '0};
                end
            end
            S_I_CMPH:
            begin
                // New head in front of the old one.
                if (pool_rdata_reg.row > ins_row_reg)
                begin
                    pool_we    = 1'b1;
                    pool_wdata = '{row: ins_row_reg, nxt: $signed({1'b0, head_reg})};
                    col_we     = 1'b1;
                    col_wdata  = '{head: fp_reg[PW-1:0], cnt: cnt_reg + AW'(1)};
                end
            end
            S_I_LINK:
            begin
                pool_we = 1'b1;
            end
            S_I_LINK2:
            begin
                pool_we    = 1'b1;
                pool_waddr = prev_reg;
                pool_wdata = '{row: prev_row_reg, nxt: $signed({1'b0, fp_reg[PW-1:0]})};
                col_we     = 1'b1;
            end
            default:
            begin
                pool_we = 1'b0;
            end
        endcase
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_count_reg <= spslb_pkg::BUS_COUNT_RST;
        end
        else if (cfg_wr_en)
        begin
            bus_count_reg <= cfg_wr_data;
        end
    end

    // Sequencer with its registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            active_reg    <= AW'(RST_NB);
            fp_reg        <= FPW'(RST_NB);
            full_reg      <= 1'b0;
            sweep_reg     <= '0;
            has_item_reg  <= 1'b0;
            second_reg    <= 1'b0;
            it_reg        <= '0;
            ins_col_reg   <= '0;
            ins_row_reg   <= '0;
            head_reg      <= '0;
            cnt_reg       <= '0;
            prev_reg      <= '0;
            prev_row_reg  <= '0;
            cur_reg       <= '0;
            status_reg    <= spslb_pkg::ST_OK;
            cf_reg        <= '0;
            ct_reg        <= '0;
            erow_reg      <= '0;
            enext_reg     <= '0;
            first_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // The result register empties when taken, unless a new result loads it.
            if (out_valid_reg && out_ready && (state_reg != S_OUT)) out_valid_reg <= 1'b0;
            case (state_reg)
                S_SWEEP:
                begin
                    sweep_reg <= sweep_reg + SCW'(1);
                    if (32'(sweep_reg) == 32'(SWEEP - 1))
                    begin
                        state_reg <= has_item_reg ? S_CNT_A : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        it_reg     <= q_item;
                        erow_reg   <= '0;
                        enext_reg  <= '0;
                        first_reg  <= '0;
                        case (q_item.mode)
                            spslb_pkg::MODE_INIT:
                            begin
                                status_reg   <= spslb_pkg::ST_OK;
                                active_reg   <= AW'(new_nb);
                                fp_reg       <= FPW'(new_nb);
                                full_reg     <= 1'b0;
                                sweep_reg    <= '0;
                                has_item_reg <= 1'b1;
                                state_reg    <= S_SWEEP;
                            end
                            spslb_pkg::MODE_ADD:
                            begin
                                if (!q_fb_ok || !q_tb_ok)
                                begin
                                    status_reg <= spslb_pkg::ST_RANGE;
                                    state_reg  <= S_CNT_A;
                                end
                                else if (full_reg || fp_high)
                                begin
                                    full_reg   <= 1'b1;
                                    status_reg <= spslb_pkg::ST_POOL_FULL;
                                    state_reg  <= S_CNT_A;
                                end
                                else
                                begin
                                    status_reg  <= spslb_pkg::ST_OK;
                                    second_reg  <= 1'b0;
                                    ins_col_reg <= BW'(q_item.from_bus);
                                    ins_row_reg <= $signed({1'b0, BW'(q_item.to_bus)});
                                    state_reg   <= S_I_COL;
                                end
                            end
                            spslb_pkg::MODE_RD_POOL:
                            begin
                                status_reg <= spslb_pkg::ST_OK;
                                state_reg  <= S_P_RD;
                            end
                            default:
                            begin
                                if (q_fb_ok)
                                begin
                                    status_reg <= spslb_pkg::ST_OK;
                                    state_reg  <= S_H_RD;
                                end
                                else
                                begin
                                    status_reg <= spslb_pkg::ST_RANGE;
                                    state_reg  <= S_CNT_A;
                                end
                            end
                        endcase
                    end
                end
                S_I_COL:
                begin
                    state_reg <= S_I_HEAD;
                end
                S_I_HEAD:
                begin
                    head_reg  <= col_rdata_reg.head;
                    cnt_reg   <= col_rdata_reg.cnt;
                    state_reg <= S_I_CMPH;
                end
                S_I_CMPH:
                begin
                    if (pool_rdata_reg.row > ins_row_reg)
                    begin
                        fp_reg    <= fp_reg + FPW'(1);
                        state_reg <= S_I_END;
                    end
                    else if (pool_rdata_reg.row == ins_row_reg)
                    begin
                        state_reg <= S_I_END;
                    end
                    else
                    begin
                        prev_reg     <= head_reg;
                        prev_row_reg <= pool_rdata_reg.row;
                        cur_reg      <= pool_rdata_reg.nxt;
                        state_reg    <= S_I_WALK;
                    end
                end
                S_I_WALK:
                begin
                    // A negative link ends the list: append at the tail.
                    state_reg <= cur_reg[NW-1] ? S_I_LINK : S_I_CMP;
                end
                S_I_CMP:
                begin
                    if (pool_rdata_reg.row < ins_row_reg)
                    begin
                        prev_reg     <= cur_reg[PW-1:0];
                        prev_row_reg <= pool_rdata_reg.row;
                        cur_reg      <= pool_rdata_reg.nxt;
                        state_reg    <= S_I_WALK;
                    end
                    else if (pool_rdata_reg.row == ins_row_reg)
                    begin
                        state_reg <= S_I_END;
                    end
                    else
                    begin
                        state_reg <= S_I_LINK;
                    end
                end
                S_I_LINK:
                begin
                    state_reg <= S_I_LINK2;
                end
                S_I_LINK2:
                begin
                    fp_reg    <= fp_reg + FPW'(1);
                    state_reg <= S_I_END;
                end
                S_I_END:
                begin
                    if (!second_reg)
                    begin
                        second_reg  <= 1'b1;
                        ins_col_reg <= BW'(it_reg.to_bus);
                        ins_row_reg <= $signed({1'b0, BW'(it_reg.from_bus)});
                        state_reg   <= S_I_COL;
                    end
                    else
                    begin
                        // Final room check after the last branch.
                        if (it_reg.last_branch && fp_high)
                        begin
                            full_reg   <= 1'b1;
                            status_reg <= spslb_pkg::ST_POOL_FULL;
                        end
                        state_reg <= S_CNT_A;
                    end
                end
                S_P_RD:
                begin
                    if (32'(it_reg.address) < 32'(POOL_ENTRIES))
                    begin
                        state_reg <= S_P_GET;
                    end
                    else
                    begin
                        erow_reg  <= '1;
                        enext_reg <= '1;
                        state_reg <= S_CNT_A;
                    end
                end
                S_P_GET:
                begin
                    erow_reg  <= spslb_pkg::EROW_W'($signed(pool_rdata_reg.row));
                    enext_reg <= spslb_pkg::ENEXT_W'($signed(pool_rdata_reg.nxt));
                    state_reg <= S_CNT_A;
                end
                S_H_RD:
                begin
                    state_reg <= S_H_GET;
                end
                S_H_GET:
                begin
                    first_reg <= spslb_pkg::FIRST_W'(col_rdata_reg.head);
                    state_reg <= S_CNT_A;
                end
                S_CNT_A:
                begin
                    has_item_reg <= 1'b0;
                    state_reg    <= S_CNT_B;
                end
                S_CNT_B:
                begin
                    cf_reg    <= fb_ok ? spslb_pkg::COUNT_W'(col_rdata_reg.cnt) : '0;
                    state_reg <= S_CNT_C;
                end
                S_CNT_C:
                begin
                    ct_reg    <= tb_ok ? spslb_pkg::COUNT_W'(col_rdata_reg.cnt) : '0;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {7'd0, first_reg, enext_reg, erow_reg,
                                          spslb_pkg::FREE_W'(fp_reg), ct_reg, cf_reg,
                                          status_reg};
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hdl/sparse_pattern_sorted_list_builder_core.sv @@
// Top level of the sparse pattern list builder: front queue, back sequencer and checks.
//
// Requests enter on the s_axis channel: mode selects init, add branch, read pool
// entry or read column; tlast marks the last branch of a run. Each request gives
// exactly one result on the m_axis channel with status, column counts, the free
// pointer and the read fields. The bus count register is written through
// cfg_wr_en / cfg_wr_data and takes effect at the next init.
// An add branch walks the list in each of its two columns, with one read of the
// entry pool per list entry walked. An init sweeps all pool and column entries,
// one per cycle. Items are handled one at a time; a two-entry input queue keeps
// taking requests while one is being worked on. After reset the same sweep runs
// with s_axis_tready low; configuration writes are taken during it.
// When the receiver stalls, the result waits in the output register, and the
// sequencer holds the next result back until the register is free.
module sparse_pattern_sorted_list_builder_core
#(
    parameter int unsigned POOL_ENTRIES = spslb_pkg::POOL_ENTRIES_DEF,
    parameter int unsigned MAX_BUSES    = spslb_pkg::MAX_BUSES_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [spslb_pkg::CFG_W-1:0]         cfg_wr_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // mode[1:0], from_bus[11:2], to_bus[21:12], address[33:22], zero fill
    input  logic [spslb_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // status[1:0], count_from[12:2], count_to[23:13], free_index[36:24],
    // entry_row[47:37], entry_next[60:48], column_first[72:61], zero fill
    output logic [spslb_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    spslb_pkg::back_stat_t stat;
    spslb_pkg::item_t      q_item;
    logic                  q_valid;

    spslb_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .stat          (stat),
        .q_valid       (q_valid),
        .q_item        (q_item)
    );

    spslb_back
    #(
        .POOL_ENTRIES (POOL_ENTRIES),
        .MAX_BUSES    (MAX_BUSES)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .stat        (stat),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata)
    );

    // No request may be taken while the pool is being cleared after reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy_clear |-> !s_axis_tready)
        else $error("request accepted during the clearing sweep");

    // The back end only pops a request that the queue holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.pop |-> q_valid)
        else $error("pop from an empty request queue");

    // A result always carries one of the defined status codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == spslb_pkg::ST_OK ||
                           m_axis_tdata[1:0] == spslb_pkg::ST_POOL_FULL ||
                           m_axis_tdata[1:0] == spslb_pkg::ST_RANGE))
        else $error("undefined status code in a result");

endmodule
